// ----- sv/y2r_pkg.sv -----
// Shared widths, coefficients, control struct and channel helpers for the YUYV to RGB565 converter.
`default_nettype none

package y2r_pkg;

    // Signed width of every intermediate channel term
    localparam int ChanW = 20;

    // Configuration port
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam logic RegIdxRangeMode = 1'b0;

    // Range modes
    localparam logic ModeStudio = 1'b0;
    localparam logic ModeFull   = 1'b1;

    // Studio-range matrix
    localparam logic signed [ChanW-1:0] CLumaOfs = ChanW'(16);
    localparam logic signed [ChanW-1:0] CLumaGain = ChanW'(298);
    localparam logic signed [ChanW-1:0] CRv = ChanW'(409);
    localparam logic signed [ChanW-1:0] CGu = ChanW'(100);
    localparam logic signed [ChanW-1:0] CGv = ChanW'(208);
    localparam logic signed [ChanW-1:0] CBu = ChanW'(516);
    localparam logic signed [ChanW-1:0] CRound = ChanW'(128);

    // Full-range matrix
    localparam logic signed [ChanW-1:0] CFullRv = ChanW'(359);
    localparam logic signed [ChanW-1:0] CFullGu = ChanW'(88);
    localparam logic signed [ChanW-1:0] CFullGv = ChanW'(183);
    localparam logic signed [ChanW-1:0] CFullBu = ChanW'(454);

    localparam logic signed [ChanW-1:0] ByteMax = ChanW'(255);

    // Chroma contribution to each channel, shared by both lanes
    typedef struct packed {
        logic signed [ChanW-1:0] r;
        logic signed [ChanW-1:0] g;
        logic signed [ChanW-1:0] b;
    } y2r_chroma_t;

    // Pipeline control from the top level to the stage modules
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic mode;
        logic mode_s1;
    } y2r_ctrl_t;

    function automatic logic [7:0] clamp_byte(input logic signed [ChanW-1:0] x);
        logic [7:0] res;
        if (x[ChanW-1])
        begin
            res = 8'd0;
        end
        else if (x > ByteMax)
        begin
            res = 8'd255;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Studio range keeps the rounding sum in 1/256 units, full range is already integral
    function automatic logic [7:0] to_channel(input logic signed [ChanW-1:0] sum,
                                              input logic full_range);
        logic signed [ChanW-1:0] v;
        v = full_range ? sum : (sum >>> 8);
        return clamp_byte(v);
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/y2r_if.sv -----
// Valid/ready channel interfaces for macropixels in and pixel pairs out.
`default_nettype none

interface y2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] y_first;
    logic [7:0] u_byte;
    logic [7:0] y_second;
    logic [7:0] v_byte;

    modport source (output valid, output y_first, output u_byte, output y_second,
                    output v_byte, input ready);
    modport sink (input valid, input y_first, input u_byte, input y_second,
                  input v_byte, output ready);
endinterface

interface y2r_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;

    modport source (output valid, output pixel_first, output pixel_second, input ready);
    modport sink (input valid, input pixel_first, input pixel_second, output ready);
endinterface

`default_nettype wire

// ----- sv/yuyv_to_rgb565_converter.sv -----
// Top level: APB mode register, two-stage valid/ready pipeline, chroma stage and two pixel lanes.
//
//   channel   direction  transaction
//   pix_in    sink       one YUYV macropixel: y_first, u_byte, y_second, v_byte
//   pix_out   source     one pixel pair: pixel_first, pixel_second (RGB565)
//   apb       slave      range_mode at byte address 0 (bit 0)
//
// One macropixel per clock unless pix_out stalls; each leaves through stage 1 and then stage 2.
// Stage 1 holds the constant products, stage 2 is the output register feeding pix_out.
// pix_in.ready follows pix_out.ready back through the two stages in the same cycle.
// rst_n clears the stage valid bits and selects studio range.
`default_nettype none

module yuyv_to_rgb565_converter
    import y2r_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    y2r_in_if.sink                   pix_in,
    y2r_out_if.source                pix_out,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0]      prdata,
    output logic                     pready
);

    logic        range_mode_reg;
    logic        range_mode_next;
    logic        mode_s1_reg;
    logic        v1_reg;
    logic        v1_next;
    logic        v2_reg;
    logic        v2_next;
    logic        ready1;
    logic        ready2;
    logic        cfg_write;
    y2r_ctrl_t   ctrl;
    y2r_chroma_t chroma;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;

    // Configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegIdxRangeMode);

    always_comb
    begin
        range_mode_next = range_mode_reg;
        if (cfg_write)
        begin
            range_mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == RegIdxRangeMode)
        begin
            prdata = ApbDataW'(range_mode_reg);
        end
    end

    // Pipeline flow control: a stage advances when empty or when its successor takes it
    assign ready2       = !v2_reg || pix_out.ready;
    assign ready1       = !v1_reg || ready2;
    assign pix_in.ready = ready1;

    assign v1_next = ready1 ? pix_in.valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_mode_reg <= ModeStudio;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end
        else
        begin
            range_mode_reg <= range_mode_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            mode_s1_reg <= range_mode_reg;
        end
    end

    assign ctrl.load_s1 = ready1;
    assign ctrl.load_s2 = ready2;
    assign ctrl.mode    = range_mode_reg;
    assign ctrl.mode_s1 = mode_s1_reg;

    y2r_chroma u_chroma (
        .clk    (clk),
        .ctrl   (ctrl),
        .u_byte (pix_in.u_byte),
        .v_byte (pix_in.v_byte),
        .chroma (chroma)
    );

    y2r_lane u_lane_first (
        .clk    (clk),
        .ctrl   (ctrl),
        .luma   (pix_in.y_first),
        .chroma (chroma),
        .pixel  (pixel_a)
    );

    y2r_lane u_lane_second (
        .clk    (clk),
        .ctrl   (ctrl),
        .luma   (pix_in.y_second),
        .chroma (chroma),
        .pixel  (pixel_b)
    );

    // Merge the lane results into one output transaction
    assign pix_out.valid        = v2_reg;
    assign pix_out.pixel_first  = pixel_a;
    assign pix_out.pixel_second = pixel_b;

endmodule

`default_nettype wire

// ----- sv/y2r_chroma.sv -----
// Shared chroma stage: constant products of U and V for the selected matrix.
`default_nettype none

module y2r_chroma
    import y2r_pkg::*;
(
    input  wire logic        clk,
    input  wire y2r_ctrl_t   ctrl,
    input  wire logic [7:0]  u_byte,
    input  wire logic [7:0]  v_byte,
    output y2r_chroma_t      chroma
);

    logic signed [ChanW-1:0] d;
    logic signed [ChanW-1:0] e;
    y2r_chroma_t             chroma_next;
    y2r_chroma_t             chroma_reg;

    // Offset-binary byte to two's complement: byte - 128
    assign d = ChanW'($signed({~u_byte[7], u_byte[6:0]}));
    assign e = ChanW'($signed({~v_byte[7], v_byte[6:0]}));

    always_comb
    begin
        if (ctrl.mode == ModeStudio)
        begin
            chroma_next.r = e * CRv + CRound;
            chroma_next.g = CRound - d * CGu - e * CGv;
            chroma_next.b = d * CBu + CRound;
        end
        else
        begin
            // Full range floors the chroma term alone; green subtracts it after the floor
            chroma_next.r = (e * CFullRv) >>> 8;
            chroma_next.g = -((d * CFullGu + e * CFullGv) >>> 8);
            chroma_next.b = (d * CFullBu) >>> 8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
        begin
            chroma_reg <= chroma_next;
        end
    end

    assign chroma = chroma_reg;

endmodule

`default_nettype wire

// ----- sv/y2r_lane.sv -----
// One pixel lane: luma term, channel sums, floor, clamp and 5-6-5 packing.
`default_nettype none

module y2r_lane
    import y2r_pkg::*;
(
    input  wire logic        clk,
    input  wire y2r_ctrl_t   ctrl,
    input  wire logic [7:0]  luma,
    input  wire y2r_chroma_t chroma,
    output logic [15:0]      pixel
);

    logic signed [ChanW-1:0] yx;
    logic signed [ChanW-1:0] luma_next;
    logic signed [ChanW-1:0] luma_reg;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic [15:0]             pixel_next;
    logic [15:0]             pixel_reg;

    assign yx = $signed(ChanW'(luma));

    always_comb
    begin
        if (ctrl.mode == ModeStudio)
        begin
            luma_next = (yx - CLumaOfs) * CLumaGain;
        end
        else
        begin
            luma_next = yx;
        end
    end

    always_comb
    begin
        red        = to_channel(luma_reg + chroma.r, ctrl.mode_s1);
        green      = to_channel(luma_reg + chroma.g, ctrl.mode_s1);
        blue       = to_channel(luma_reg + chroma.b, ctrl.mode_s1);
        pixel_next = pack565(red, green, blue);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
        begin
            luma_reg <= luma_next;
        end
        if (ctrl.load_s2)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

// ----- sv/y2r_checker.sv -----
// Port-level checker for the converter and its bind to the top level.
`default_nettype none

module y2r_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] pixel_first,
    input wire logic [15:0] pixel_second,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic        pready,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    logic in_acc;
    logic mode_wr;

    assign in_acc  = in_valid && in_ready;
    assign mode_wr = psel && penable && pwrite && pready && !paddr[2];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_first) && $stable(pixel_second))
        else $error("stalled output transaction changed");

    // A draining output never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // An accepted transaction reaches the output when the output drains while it is held in stage 1
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 out_ready |=> out_valid)
        else $error("accepted transaction did not reach the output");

    // The mode register reads back what was written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr ##1 !paddr[2] |-> prdata[0] == $past(pwdata[0]))
        else $error("range mode readback mismatch");

endmodule

bind yuyv_to_rgb565_converter y2r_checker u_y2r_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pix_in.valid),
    .in_ready     (pix_in.ready),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .pixel_first  (pix_out.pixel_first),
    .pixel_second (pix_out.pixel_second),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

`default_nettype wire
